@@ rtl/ssr_pkg.sv @@
// Shared constants, types and codes of the systematic resampler.
package ssr_pkg;

  // Sizes of the particle store and of the fixed-point fields.
  localparam int MAX_PARTICLES = 1024;
  localparam int FRACTION_BITS = 24;
  localparam int INDEX_W       = $clog2(MAX_PARTICLES);
  localparam int COUNT_W       = INDEX_W + 1;
  localparam int WEIGHT_W      = FRACTION_BITS + 1;
  localparam int DRAW_W        = FRACTION_BITS;
  localparam int CUM_W         = WEIGHT_W + INDEX_W;
  localparam int TARGET_W      = DRAW_W + COUNT_W;
  localparam int PROD_W        = CUM_W + COUNT_W;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(MAX_PARTICLES);

  // Command kinds.
  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_START   = 2'd1;
  localparam logic [1:0] KIND_REQUEST = 2'd2;

  // One input item.
  typedef struct packed {
    logic [1:0]          kind;
    logic [INDEX_W-1:0]  weight_index;
    logic [WEIGHT_W-1:0] weight_value;
    logic [DRAW_W-1:0]   uniform_draw;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic [INDEX_W-1:0] ancestor;
    logic               overran;
    logic               last;
  } result_t;

  // Scan sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD0,
    ST_MUL,
    ST_CMP,
    ST_ACC
  } state_t;

endpackage

@@ rtl/ssr_weight_ram.sv @@
// Single-port weight memory with a registered read.
module ssr_weight_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 25
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on request; the read is registered and runs every cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/ssr_scan.sv @@
// Scan sequencer: loads the weight store, then walks it to pick the ancestor for each request.
module ssr_scan
  import ssr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  cmd_t               cmd,
  input  logic [COUNT_W-1:0] count,
  output logic               busy,
  output logic               done,
  output result_t            result
);

  state_t state, state_next;

  logic [CUM_W-1:0]    cum;
  logic [INDEX_W-1:0]  scan_index;
  logic [COUNT_W-1:0]  position;
  logic [DRAW_W-1:0]   draw;
  logic [TARGET_W-1:0] target;
  logic [PROD_W-1:0]   prod;

  logic                ram_we;
  logic [INDEX_W-1:0]  ram_addr;
  logic [WEIGHT_W-1:0] ram_rdata;

  logic [COUNT_W-1:0]  index_inc;
  logic                below;
  logic                advance;
  logic                run_open;
  logic                emit;

  // Weight store.
  ssr_weight_ram #(
    .DEPTH(MAX_PARTICLES),
    .WIDTH(WEIGHT_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (cmd.weight_value),
    .rdata (ram_rdata)
  );

  // Scan decisions.
  assign index_inc = {1'b0, scan_index} + COUNT_W'(1);
  assign below     = prod < PROD_W'(target);
  assign advance   = below && (index_inc < count);
  assign run_open  = position < count;
  assign emit      = (state == ST_CMP) && !advance;
  assign busy      = (state != ST_IDLE);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (cmd.kind)
            KIND_START:   state_next = ST_LOAD0;
            KIND_REQUEST: state_next = run_open ? ST_MUL : ST_IDLE;
            default:      state_next = ST_IDLE;
          endcase
        end
      end
      ST_LOAD0: state_next = ST_IDLE;
      ST_MUL:   state_next = ST_CMP;
      ST_CMP:   state_next = advance ? ST_ACC : ST_IDLE;
      ST_ACC:   state_next = ST_MUL;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Memory controls.
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = '0;
    case (state)
      ST_IDLE: begin
        if (start && (cmd.kind == KIND_LOAD)) begin
          ram_we   = 1'b1;
          ram_addr = cmd.weight_index;
        end
      end
      ST_CMP:  ram_addr = index_inc[INDEX_W-1:0];
      default: ram_addr = '0;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scan state: cumulative weight, scan index, output position and draw.
  always_ff @(posedge clk) begin
    if (rst) begin
      cum        <= '0;
      scan_index <= '0;
      position   <= '0;
      draw       <= '0;
      done       <= 1'b0;
    end else begin
      done <= emit;
      case (state)
        ST_IDLE: begin
          if (start && (cmd.kind == KIND_START)) begin
            draw       <= cmd.uniform_draw;
            scan_index <= '0;
            position   <= '0;
          end
        end
        ST_LOAD0: cum <= CUM_W'(ram_rdata);
        ST_CMP: begin
          if (advance) begin
            scan_index <= index_inc[INDEX_W-1:0];
          end else begin
            position <= position + COUNT_W'(1);
          end
        end
        ST_ACC:  cum <= cum + CUM_W'(ram_rdata);
        default: cum <= cum;
      endcase
    end
  end

  // Target, scaled cumulative weight and the result payload.
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && start) begin
      target <= {position, {FRACTION_BITS{1'b0}}} + TARGET_W'(draw);
    end
    if (state == ST_MUL) begin
      prod <= {{COUNT_W{1'b0}}, cum} * {{CUM_W{1'b0}}, count};
    end
    if (emit) begin
      result.ancestor <= scan_index;
      result.overran  <= below;
      result.last     <= (position + COUNT_W'(1) == count);
    end
  end

`ifndef SYNTHESIS
  // A result only follows a compare step.
  a_done_after_cmp: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_CMP)
    else $error("result strobe without a preceding compare");

  // Results are never strobed in consecutive cycles.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // An accumulate step only follows a scan index below the count.
  a_acc_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACC) |-> ({1'b0, scan_index} < count))
    else $error("scan advanced past the last particle");

  // Outside a command the scan position does not move.
  a_idle_stable: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_IDLE) && !start) |=> ($stable(scan_index) && $stable(position)))
    else $error("scan state changed while idle");
`endif

endmodule

@@ rtl/systematic_resampler_top.sv @@
// Top level of the systematic resampler: particle count register and scan.
//
//   Channel   Handshake              Payload
//   command   start / busy           cmd (cmd_t)
//   result    done strobe            result (result_t)
//   config    cfg_valid / cfg_ready  cfg_data (particle count)
//
// A weight load is written while idle; a start takes the draw and then reads
// the first weight. A request that yields an ancestor is a multiply and a
// compare, plus one step for each particle the scan steps over; each step is a
// weight read, an accumulate, a multiply by the count and a compare. Reset
// clears the scan state and sets the count to 1024; the weight store holds no
// reset value. Done is high for one cycle; the result stays until the next.
module systematic_resampler_top
  import ssr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  cmd_t               cmd,
  output logic               busy,
  output logic               done,
  output result_t            result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data
);

  logic [COUNT_W-1:0] particle_count;
  logic [COUNT_W-1:0] count_in_use;

  // Particle count register, always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      particle_count <= COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      particle_count <= cfg_data;
    end
  end

  // Counts above the store size use the whole store.
  assign count_in_use = (particle_count > COUNT_RESET) ? COUNT_RESET : particle_count;

  ssr_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .count  (count_in_use),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

endmodule
